### rtl/nprt_pkg.sv
`default_nettype none

package nprt_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned TILE_SIDE_DEF       = 64;

  localparam int unsigned IDX_W  = 8;
  localparam int unsigned COMP_W = 6;
  localparam int unsigned RGB_W  = 3 * COMP_W;
  localparam int unsigned DIST_W = 14;
  localparam int unsigned ADDR_W = 12;

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_MAP   = 2'd1;
  localparam action_t ACT_PIXEL = 2'd2;
  localparam action_t ACT_NONE  = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_MATCH = 2'd1;
  localparam kind_t KIND_PIXEL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PIX  = 3'b100
  } state_t;

  // travels with each palette entry down the scan pipeline
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

### rtl/nprt_dist.sv
`default_nettype none

module nprt_dist (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [nprt_pkg::RGB_W-1:0]    src,
  input  wire logic [nprt_pkg::RGB_W-1:0]    entry,
  input  wire nprt_pkg::tag_t                tag_in,
  output logic      [nprt_pkg::DIST_W-1:0]   dist_r,
  output nprt_pkg::tag_t                     tag_r
);

  localparam int unsigned CW = nprt_pkg::COMP_W;
  localparam int unsigned SW = 2 * CW;

  logic [CW-1:0] dr, dg, db;
  logic [SW-1:0] sqr, sqg, sqb;
  logic [nprt_pkg::DIST_W-1:0] dist_nxt;

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    dr  = absdiff(src[3*CW-1:2*CW], entry[3*CW-1:2*CW]);
    dg  = absdiff(src[2*CW-1:CW],   entry[2*CW-1:CW]);
    db  = absdiff(src[CW-1:0],      entry[CW-1:0]);
    sqr = SW'(dr) * SW'(dr);
    sqg = SW'(dg) * SW'(dg);
    sqb = SW'(db) * SW'(db);
    dist_nxt = nprt_pkg::DIST_W'(sqr) + nprt_pkg::DIST_W'(sqg) + nprt_pkg::DIST_W'(sqb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

endmodule

`default_nettype wire

### rtl/nearest_palette_remap_transpose.sv
// Nearest-colour palette mapper with tile remap. One request at a time, started
// by start while busy is low; every request except the ignored fourth action
// gives one result, shown for a single cycle on out_valid that the receiver
// must take. Target loads give their acknowledge the next cycle with busy kept
// low, so loads may follow each other every cycle. A pixel request reads the
// conversion table into a register, then registers its result in the pixel
// state with busy high. A map request scans the whole target palette memory
// at one entry a cycle through the palette read and distance registers, then
// registers its result; the single palette read port sets the map rate. Pixel
// addresses are the transposed, column-flipped positions in a TILE_SIDE square
// tile, counted in row-major order and wrapping at the end of the tile.
`default_nettype none

module nearest_palette_remap_transpose #(
  parameter int unsigned PALETTE_ENTRIES = nprt_pkg::PALETTE_ENTRIES_DEF,
  parameter int unsigned TILE_SIDE       = nprt_pkg::TILE_SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_action,
  input  wire logic [7:0]                    in_entry_index,
  input  wire logic [7:0]                    in_red,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_blue,
  input  wire logic [7:0]                    in_pixel_in,
  output logic                               out_valid,
  output logic [1:0]                         out_result_kind,
  output logic [7:0]                         out_match_index,
  output logic [13:0]                        out_match_distance,
  output logic [11:0]                        out_pixel_address,
  output logic [7:0]                         out_pixel_out
);

  localparam int unsigned IW   = nprt_pkg::IDX_W;
  localparam int unsigned RW   = nprt_pkg::RGB_W;
  localparam int unsigned DW   = nprt_pkg::DIST_W;
  localparam int unsigned PAW  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned TW   = $clog2(TILE_SIDE);
  localparam int unsigned TABD = 1 << IW;
  localparam int unsigned FAW  = 2 * TW + 1;

  // ---------------------------------------------------------------- control
  nprt_pkg::state_t state_r, state_nxt;
  logic             accept;
  logic             idx_ok;

  logic [IW-1:0]    cnt_r;
  logic             issue_r;
  logic             issue_last;

  logic [RW-1:0]    src_r;
  logic [IW-1:0]    map_idx_r;
  logic             map_ok_r;

  logic [TW-1:0]    row_r, col_r;
  logic [FAW-1:0]   addr_full;

  // ---------------------------------------------------------------- memories
  logic [RW-1:0]    pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_vld_r;
  logic [RW-1:0]    pal_rd_r;
  logic             pal_ok_r;
  logic [PAW-1:0]   pal_ra;
  logic [PAW-1:0]   pal_wa;
  logic             pal_we;

  logic [IW-1:0]    tab_mem [TABD];
  logic [TABD-1:0]  tab_vld_r;
  logic [IW-1:0]    tab_rd_r;
  logic             tab_ok_r;
  logic             tab_we;

  nprt_pkg::tag_t   rd_tag_r, issue_tag;
  nprt_pkg::tag_t   d_tag;
  logic [DW-1:0]    d_dist;
  logic [RW-1:0]    entry;

  logic [IW-1:0]    best_r, best_nxt;
  logic [DW-1:0]    best_d_r, best_d_nxt;
  logic             finish;

  assign busy   = (state_r != nprt_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign idx_ok = ((IW + 1)'(in_entry_index) < (IW + 1)'(PALETTE_ENTRIES));

  // scan issue
  assign issue_last = (cnt_r == IW'(PALETTE_ENTRIES - 1));
  always_comb begin
    issue_tag      = '0;
    issue_tag.vld  = issue_r;
    issue_tag.last = issue_last;
    issue_tag.idx  = cnt_r;
  end

  assign pal_ra = cnt_r[PAW-1:0];
  assign pal_wa = in_entry_index[PAW-1:0];
  assign pal_we = accept && (in_action == nprt_pkg::ACT_LOAD) && idx_ok;
  assign tab_we = finish && map_ok_r;

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_wa] <= {in_red[5:0], in_green[5:0], in_blue[5:0]};
    end
    pal_rd_r <= pal_mem[pal_ra];
    pal_ok_r <= pal_vld_r[pal_ra];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[map_idx_r] <= best_nxt;
    end
    tab_rd_r <= tab_mem[in_pixel_in];
    tab_ok_r <= tab_vld_r[in_pixel_in];
  end

  // never-written entries read as zero
  assign entry = pal_ok_r ? pal_rd_r : '0;

  nprt_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .src    (src_r),
    .entry  (entry),
    .tag_in (rd_tag_r),
    .dist_r (d_dist),
    .tag_r  (d_tag)
  );

  // running minimum; lowest index wins ties
  always_comb begin
    best_nxt   = best_r;
    best_d_nxt = best_d_r;
    if (d_tag.vld && ((d_tag.idx == '0) || (d_dist < best_d_r))) begin
      best_nxt   = d_tag.idx;
      best_d_nxt = d_dist;
    end
  end
  assign finish = d_tag.vld && d_tag.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nprt_pkg::ST_IDLE: begin
        if (accept && in_action == nprt_pkg::ACT_MAP) begin
          state_nxt = nprt_pkg::ST_SCAN;
        end else if (accept && in_action == nprt_pkg::ACT_PIXEL) begin
          state_nxt = nprt_pkg::ST_PIX;
        end
      end
      nprt_pkg::ST_SCAN: begin
        if (finish) begin
          state_nxt = nprt_pkg::ST_IDLE;
        end
      end
      nprt_pkg::ST_PIX: begin
        state_nxt = nprt_pkg::ST_IDLE;
      end
      default: state_nxt = nprt_pkg::ST_IDLE;
    endcase
  end

  assign addr_full = FAW'(TILE_SIDE) * FAW'(col_r) + FAW'(TILE_SIDE - 1) - FAW'(row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= nprt_pkg::ST_IDLE;
      issue_r   <= 1'b0;
      cnt_r     <= '0;
      rd_tag_r  <= '0;
      pal_vld_r <= '0;
      tab_vld_r <= '0;
      row_r     <= '0;
      col_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_tag_r  <= issue_tag;
      out_valid <= 1'b0;
      if (pal_we) begin
        pal_vld_r[pal_wa] <= 1'b1;
      end
      if (tab_we) begin
        tab_vld_r[map_idx_r] <= 1'b1;
      end
      if (accept && in_action == nprt_pkg::ACT_LOAD) begin
        out_valid <= 1'b1;
      end
      if (accept && in_action == nprt_pkg::ACT_MAP) begin
        issue_r <= 1'b1;
        cnt_r   <= '0;
      end else if (issue_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (issue_last) begin
          issue_r <= 1'b0;
        end
      end
      if (finish) begin
        out_valid <= 1'b1;
      end
      if (state_r == nprt_pkg::ST_PIX) begin
        out_valid <= 1'b1;
        if (col_r == TW'(TILE_SIDE - 1)) begin
          col_r <= '0;
          row_r <= (row_r == TW'(TILE_SIDE - 1)) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r   <= best_nxt;
    best_d_r <= best_d_nxt;
    if (accept && in_action == nprt_pkg::ACT_MAP) begin
      src_r     <= {in_red[7:2], in_green[7:2], in_blue[7:2]};
      map_idx_r <= in_entry_index;
      map_ok_r  <= idx_ok;
    end
    if (accept && in_action == nprt_pkg::ACT_LOAD) begin
      out_result_kind    <= nprt_pkg::KIND_LOAD;
      out_match_index    <= '0;
      out_match_distance <= '0;
      out_pixel_address  <= '0;
      out_pixel_out      <= '0;
    end else if (finish) begin
      out_result_kind    <= nprt_pkg::KIND_MATCH;
      out_match_index    <= best_nxt;
      out_match_distance <= best_d_nxt;
      out_pixel_address  <= '0;
      out_pixel_out      <= '0;
    end else if (state_r == nprt_pkg::ST_PIX) begin
      out_result_kind    <= nprt_pkg::KIND_PIXEL;
      out_match_index    <= '0;
      out_match_distance <= '0;
      out_pixel_address  <= addr_full[nprt_pkg::ADDR_W-1:0];
      out_pixel_out      <= tab_ok_r ? tab_rd_r : '0;
    end
  end

  // ---------------------------------------------------------------- checks
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_long_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != nprt_pkg::KIND_LOAD) |-> $fell(busy))
    else $error("map or pixel result outside the end of a request");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == nprt_pkg::ACT_LOAD) |=>
      (out_valid && out_result_kind == nprt_pkg::KIND_LOAD && !busy))
    else $error("load request not acknowledged next cycle");

  a_scan_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_r || rd_tag_r.vld || d_tag.vld) |-> (state_r == nprt_pkg::ST_SCAN))
    else $error("palette scan active outside the scan state");

  a_ignored_action: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == nprt_pkg::ACT_NONE) |=> (!busy && !out_valid))
    else $error("ignored request produced activity");

endmodule

`default_nettype wire

### verif/nearest_palette_remap_transpose_tb.sv
`default_nettype none

module nearest_palette_remap_transpose_tb;

  localparam int unsigned PALETTE_ENTRIES_DEF = nprt_pkg::PALETTE_ENTRIES_DEF;
  localparam int unsigned TILE_SIDE_DEF       = nprt_pkg::TILE_SIDE_DEF;
  localparam int unsigned IDX_W               = nprt_pkg::IDX_W;
  localparam int unsigned COMP_W              = nprt_pkg::COMP_W;
  localparam int unsigned RGB_W               = nprt_pkg::RGB_W;
  localparam int unsigned DIST_W              = nprt_pkg::DIST_W;
  localparam int unsigned ADDR_W              = nprt_pkg::ADDR_W;

  localparam int unsigned TILE_AREA      = TILE_SIDE_DEF * TILE_SIDE_DEF;
  localparam int unsigned RANDOM_REQS    = 950;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct {
    nprt_pkg::action_t action;
    logic [7:0]        entry_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        pixel_in;
    bit                drain_first;
    int unsigned       gap;
  } req_t;

  typedef struct packed {
    nprt_pkg::kind_t   kind;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pix;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_entry_index = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_pixel_in = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_match_index;
  logic [13:0] out_match_distance;
  logic [11:0] out_pixel_address;
  logic [7:0]  out_pixel_out;

  // local copy of the block state
  logic [RGB_W-1:0] tgt_pal [PALETTE_ENTRIES_DEF];
  logic [IDX_W-1:0] conv_tbl [256];
  int unsigned      tile_pos;

  req_t        req_queue[$];
  res_t        awaited_results[$];
  req_t        cur_req;
  int unsigned gap_left;
  bit          gap_armed;
  int unsigned fail_cnt;
  int unsigned idle_cycles;

  nearest_palette_remap_transpose uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_pixel_in        (in_pixel_in),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_match_index    (out_match_index),
    .out_match_distance (out_match_distance),
    .out_pixel_address  (out_pixel_address),
    .out_pixel_out      (out_pixel_out)
  );

  always #4 clk = ~clk;

  function automatic int unsigned comp_dist2(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    int diff;
    diff = int'(a) - int'(b);
    return unsigned'(diff * diff);
  endfunction

  // applies one request to the local state and returns the result it should give
  function automatic res_t remap_predict(req_t rq);
    res_t             res;
    logic [COMP_W-1:0] sr, sg, sb;
    logic [RGB_W-1:0] ent;
    int unsigned      d, best, best_d, row, col;
    res = '0;
    res.kind = nprt_pkg::kind_t'(rq.action);
    case (rq.action)
      nprt_pkg::ACT_LOAD: begin
        tgt_pal[rq.entry_index] = {rq.red[COMP_W-1:0], rq.green[COMP_W-1:0],
                                   rq.blue[COMP_W-1:0]};
      end
      nprt_pkg::ACT_MAP: begin
        sr = rq.red[7:2];
        sg = rq.green[7:2];
        sb = rq.blue[7:2];
        best = 0;
        best_d = 0;
        for (int unsigned j = 0; j < PALETTE_ENTRIES_DEF; j++) begin
          ent = tgt_pal[IDX_W'(j)];
          d = comp_dist2(sr, ent[3*COMP_W-1:2*COMP_W]) + comp_dist2(sg, ent[2*COMP_W-1:COMP_W])
              + comp_dist2(sb, ent[COMP_W-1:0]);
          // strict compare keeps the lowest index on a tie
          if (j == 0 || d < best_d) begin
            best = j;
            best_d = d;
          end
        end
        conv_tbl[rq.entry_index] = IDX_W'(best);
        res.index = IDX_W'(best);
        res.distance = DIST_W'(best_d);
      end
      nprt_pkg::ACT_PIXEL: begin
        row = tile_pos / TILE_SIDE_DEF;
        col = tile_pos % TILE_SIDE_DEF;
        res.addr = ADDR_W'(TILE_SIDE_DEF * col + TILE_SIDE_DEF - 1 - row);
        res.pix = conv_tbl[rq.pixel_in];
        tile_pos = (tile_pos + 1) % TILE_AREA;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap(bit burst);
    int unsigned sel;
    if (burst)
      return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      return 0;
    else if (sel < 88)
      return $urandom_range(1, 3);
    else if (sel < 97)
      return $urandom_range(10, 60);
    return $urandom_range(100, 300);
  endfunction

  task automatic add_req(nprt_pkg::action_t act, logic [7:0] idx, logic [7:0] r,
                         logic [7:0] g, logic [7:0] b, logic [7:0] pix, bit drain,
                         bit burst);
    req_t rq;
    rq.action = act;
    rq.entry_index = idx;
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    rq.pixel_in = pix;
    rq.drain_first = drain;
    rq.gap = pick_gap(burst);
    req_queue.push_back(rq);
  endtask

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  // request driver: predicts on acceptance, then offers the next queued request
  always @(posedge clk) begin : drive_requests
    bit launch;
    launch = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy && cur_req.action != nprt_pkg::ACT_NONE)
        awaited_results.push_back(remap_predict(cur_req));
      if (!start || !busy) begin
        if (req_queue.size() != 0) begin
          if (!gap_armed) begin
            gap_left = req_queue[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left != 0)
            gap_left--;
          else if (!(req_queue[0].drain_first && awaited_results.size() != 0))
            launch = 1'b1;
        end
        if (launch) begin
          cur_req = req_queue.pop_front();
          gap_armed = 1'b0;
          in_action <= cur_req.action;
          in_entry_index <= cur_req.entry_index;
          in_red <= cur_req.red;
          in_green <= cur_req.green;
          in_blue <= cur_req.blue;
          in_pixel_in <= cur_req.pixel_in;
        end else begin
          in_action <= 2'($urandom);
          in_entry_index <= 8'($urandom);
          in_red <= 8'($urandom);
          in_green <= 8'($urandom);
          in_blue <= 8'($urandom);
          in_pixel_in <= 8'($urandom);
        end
        start <= launch;
      end
    end
  end

  // result monitor; sampled mid-cycle, the strobe is stable for the whole cycle
  always @(negedge clk) begin : check_results
    res_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        idle_cycles = 0;
        if (awaited_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("result with nothing outstanding: kind %0h", out_result_kind);
        end else begin
          want = awaited_results.pop_front();
          if (out_result_kind !== want.kind)
            report_field("result_kind", 32'(want.kind), 32'(out_result_kind));
          if (out_match_index !== want.index)
            report_field("match_index", 32'(want.index), 32'(out_match_index));
          if (out_match_distance !== want.distance)
            report_field("match_distance", 32'(want.distance), 32'(out_match_distance));
          if (out_pixel_address !== want.addr)
            report_field("pixel_address", 32'(want.addr), 32'(out_pixel_address));
          if (out_pixel_out !== want.pix)
            report_field("pixel_out", 32'(want.pix), 32'(out_pixel_out));
        end
      end else if (start && !busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned issued, sel;
    bit          burst;
    logic [5:0]  last_r, last_g, last_b;

    foreach (tgt_pal[i]) tgt_pal[i] = '0;
    foreach (conv_tbl[i]) conv_tbl[i] = '0;
    tile_pos = 0;
    fail_cnt = 0;
    idle_cycles = 0;
    gap_armed = 1'b0;
    gap_left = 0;
    cur_req = '{default: '0};

    // directed: empty search at worst distance, masking, ties, index extremes
    add_req(nprt_pkg::ACT_MAP,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_NONE,  8'd77,  8'd1,   8'd2,   8'd3,   8'd4,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_LOAD,  8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 1'b1);
    add_req(nprt_pkg::ACT_LOAD,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1);
    add_req(nprt_pkg::ACT_LOAD,  8'd5,   8'd10,  8'd20,  8'd30,  8'd0,   1'b0, 1'b1);
    add_req(nprt_pkg::ACT_LOAD,  8'd9,   8'd10,  8'd20,  8'd30,  8'd0,   1'b0, 1'b1);
    add_req(nprt_pkg::ACT_MAP,   8'd255, 8'd43,  8'd83,  8'd123, 8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_MAP,   8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_MAP,   8'd1,   8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b1);
    add_req(nprt_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 1'b0, 1'b1);
    add_req(nprt_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   1'b0, 1'b1);
    add_req(nprt_pkg::ACT_LOAD,  8'd255, 8'd63,  8'd192, 8'd127, 8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_MAP,   8'd170, 8'd252, 8'd1,   8'd255, 8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_NONE,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    add_req(nprt_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd170, 1'b1, 1'b0);
    add_req(nprt_pkg::ACT_MAP,   8'd85,  8'd128, 8'd64,  8'd32,  8'd0,   1'b0, 1'b0);
    add_req(nprt_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd85,  1'b0, 1'b0);

    // random mix; maps often aim close to a recent load so small distances occur
    issued = 0;
    burst = 1'b0;
    last_r = '0;
    last_g = '0;
    last_b = '0;
    while (issued < RANDOM_REQS) begin
      if (issued % 32 == 0)
        burst = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        add_req(nprt_pkg::ACT_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 1'b0, burst);
      end else begin
        if (sel < 40) begin
          if ($urandom_range(0, 9) != 0) begin
            last_r = 6'($urandom);
            last_g = 6'($urandom);
            last_b = 6'($urandom);
            add_req(nprt_pkg::ACT_LOAD, 8'($urandom), {2'b00, last_r}, {2'b00, last_g},
                    {2'b00, last_b}, 8'($urandom), 1'b0, burst);
          end else begin
            add_req(nprt_pkg::ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 1'b0, burst);
          end
        end else if (sel < 58) begin
          if ($urandom_range(0, 1) == 0)
            add_req(nprt_pkg::ACT_MAP, 8'($urandom), {last_r, 2'($urandom)},
                    {last_g, 2'($urandom)}, {last_b, 2'($urandom)}, 8'($urandom),
                    1'b0, burst);
          else
            add_req(nprt_pkg::ACT_MAP, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 1'b0, burst);
        end else begin
          add_req(nprt_pkg::ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), ($urandom_range(0, 199) == 0), burst);
        end
      end
      issued++;
    end

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (req_queue.size() != 0 || start || awaited_results.size() != 0);
    repeat (PALETTE_ENTRIES_DEF + 16) @(negedge clk);

    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
